/* sv/assert_macros.svh */
// Assertion macros for the checker file of the box filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is low.
`define BFS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds through reset.
`define BFS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

/* sv/bfs_pkg.sv */
// Shared types and constants of the separable 7x7 box filter.
package bfs_pkg;

    localparam int WIN         = 7;
    localparam int HALF_WIN    = 3;
    localparam int PIX_W       = 8;
    localparam int CFG_W       = 11;
    localparam int SUM_W       = 11;
    localparam int CSUM_W      = 14;
    localparam int X_W         = 15;
    localparam int RECIP_SHIFT = 20;
    localparam int PROD_W      = 30;
    localparam int QUO_W       = PROD_W - RECIP_SHIFT;
    localparam int COORD_W     = 10;
    localparam int OUT_PAD_W   = 4;

    // floor(x / 49) == (x * 21400) >> 20 for every x below 43690
    localparam logic [X_W-1:0]   RECIP_MUL  = 15'd21400;
    localparam logic [X_W-1:0]   ROUND_BIAS = 15'd24;
    localparam logic [PIX_W-1:0] PIX_MAX    = 8'hFF;

    localparam logic [2:0] LAST_LINE = 3'd6;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd512;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd512;

    typedef logic [PIX_W-1:0]   t_pix;
    typedef logic [CFG_W-1:0]   t_cfg;
    typedef logic [SUM_W-1:0]   t_hsum;
    typedef logic [CSUM_W-1:0]  t_csum;
    typedef logic [X_W-1:0]     t_x;
    typedef logic [PROD_W-1:0]  t_prod;
    typedef logic [QUO_W-1:0]   t_quo;
    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [2:0]         t_line;

    typedef struct packed {
        logic row_zero;
        logic row_ge7;
        logic emit;
        logic done;
    } t_flags;

    typedef struct packed {
        t_coord centre_row;
        t_coord centre_col;
        logic   done;
    } t_meta;

endpackage

/* sv/bfs_front.sv */
// Position counters, row pixel window and horizontal 7-sum of the box filter.
module bfs_front #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  bfs_pkg::t_pix     i_pixel,
    input  logic              i_frame_start,
    input  bfs_pkg::t_cfg     i_width_cfg,
    input  bfs_pkg::t_cfg     i_height_cfg,
    output logic              o_emit_w,
    output bfs_pkg::t_hsum    o_hs,
    output logic [$clog2(MAX_COLS)-1:0] o_cc,
    output bfs_pkg::t_line    o_line,
    output bfs_pkg::t_flags   o_flags,
    output bfs_pkg::t_coord   o_centre_row
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);

    typedef logic [CW-1:0] t_col;
    typedef logic [CW:0]   t_colx;
    typedef logic [RW-1:0] t_row;
    typedef logic [RW:0]   t_rowx;

    t_col           r_col;
    t_row           r_row;
    bfs_pkg::t_line r_line;
    bfs_pkg::t_pix  r_win [bfs_pkg::WIN-1];

    t_colx          w;
    t_rowx          h;
    t_colx          col_a;
    t_rowx          row_a;
    bfs_pkg::t_line line_a;
    t_col           col;
    t_row           row;
    t_colx          n_col;
    t_rowx          n_row;
    bfs_pkg::t_line n_line;
    bfs_pkg::t_hsum hs;
    t_row           crow;

    always_comb begin
        if (i_width_cfg < bfs_pkg::t_cfg'(bfs_pkg::WIN)) begin
            w = t_colx'(bfs_pkg::WIN);
        end else if (32'(i_width_cfg) > MAX_COLS) begin
            w = t_colx'(MAX_COLS);
        end else begin
            w = t_colx'(i_width_cfg);
        end
        if (i_height_cfg < bfs_pkg::t_cfg'(bfs_pkg::WIN)) begin
            h = t_rowx'(bfs_pkg::WIN);
        end else if (32'(i_height_cfg) > MAX_ROWS) begin
            h = t_rowx'(MAX_ROWS);
        end else begin
            h = t_rowx'(i_height_cfg);
        end
    end

    always_comb begin
        col_a  = t_colx'(r_col);
        row_a  = t_rowx'(r_row);
        line_a = r_line;
        if (i_frame_start) begin
            col_a  = '0;
            row_a  = '0;
            line_a = '0;
        end
        if (col_a >= w) begin
            col_a  = '0;
            row_a  = row_a + t_rowx'(1);
            line_a = (line_a == bfs_pkg::LAST_LINE) ? '0 : line_a + 3'd1;
        end
        if (row_a >= h) begin
            row_a  = '0;
            line_a = '0;
        end
        col = col_a[CW-1:0];
        row = row_a[RW-1:0];

        n_col  = t_colx'(col) + t_colx'(1);
        n_row  = t_rowx'(row);
        n_line = line_a;
        if (n_col >= w) begin
            n_col  = '0;
            n_row  = n_row + t_rowx'(1);
            n_line = (n_line == bfs_pkg::LAST_LINE) ? '0 : n_line + 3'd1;
            if (n_row >= h) begin
                n_row  = '0;
                n_line = '0;
            end
        end
    end

    always_comb begin
        hs = bfs_pkg::t_hsum'(i_pixel);
        for (int i = 0; i < bfs_pkg::WIN - 1; i++) begin
            hs = hs + bfs_pkg::t_hsum'(r_win[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_line <= '0;
            for (int i = 0; i < bfs_pkg::WIN - 1; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_accept) begin
            r_col  <= n_col[CW-1:0];
            r_row  <= n_row[RW-1:0];
            r_line <= n_line;
            for (int i = 0; i < bfs_pkg::WIN - 2; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[bfs_pkg::WIN-2] <= i_pixel;
        end
    end

    assign crow = row - t_row'(bfs_pkg::HALF_WIN);

    assign o_emit_w         = col >= t_col'(bfs_pkg::WIN - 1);
    assign o_hs             = hs;
    assign o_cc             = col - t_col'(bfs_pkg::HALF_WIN);
    assign o_line           = line_a;
    assign o_centre_row     = bfs_pkg::t_coord'(crow);
    assign o_flags.row_zero = row == '0;
    assign o_flags.row_ge7  = row >= t_row'(bfs_pkg::WIN);
    assign o_flags.emit     = row >= t_row'(bfs_pkg::WIN - 1);
    assign o_flags.done     = (t_rowx'(row) == h - t_rowx'(1)) &&
                              (t_colx'(col) == w - t_colx'(1));

endmodule

/* sv/bfs_sum_mem.sv */
// Line buffers of horizontal sums and per-column running sums with fill mark.
module bfs_sum_mem #(
    parameter int COLS_W = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rd_en,
    input  bfs_pkg::t_line      i_rd_line,
    input  logic [COLS_W-1:0]   i_rd_col,
    input  logic                i_wr_en,
    input  bfs_pkg::t_line      i_wr_line,
    input  logic [COLS_W-1:0]   i_wr_col,
    input  bfs_pkg::t_hsum      i_wr_hs,
    input  bfs_pkg::t_csum      i_wr_cs,
    output bfs_pkg::t_hsum      o_old_hs,
    output bfs_pkg::t_csum      o_col_sum
);

    localparam int COLS   = 2 ** COLS_W;
    localparam int LDEPTH = bfs_pkg::WIN * COLS;

    typedef logic [COLS_W:0] t_fill;

    bfs_pkg::t_hsum r_line_mem [LDEPTH];
    bfs_pkg::t_csum r_col_mem  [COLS];

    bfs_pkg::t_hsum r_old_hs;
    bfs_pkg::t_csum r_col_rd;
    t_fill          r_fill;
    logic           r_fill_ok;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_line_mem[{i_wr_line, i_wr_col}] <= i_wr_hs;
            r_col_mem[i_wr_col]               <= i_wr_cs;
        end
        if (i_rd_en) begin
            r_old_hs <= r_line_mem[{i_rd_line, i_rd_col}];
            r_col_rd <= r_col_mem[i_rd_col];
        end
    end

    // column sums beyond the highest column written since reset read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_fill_ok <= 1'b0;
        end else begin
            if (i_wr_en && (t_fill'(i_wr_col) >= r_fill)) begin
                r_fill <= t_fill'(i_wr_col) + t_fill'(1);
            end
            if (i_rd_en) begin
                r_fill_ok <= t_fill'(i_rd_col) < r_fill;
            end
        end
    end

    assign o_old_hs  = r_old_hs;
    assign o_col_sum = r_fill_ok ? r_col_rd : '0;

endmodule

/* sv/bfs_div.sv */
// Divide-by-49 by reciprocal multiply, saturation and output register.
module bfs_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  bfs_pkg::t_x     i_x,
    input  bfs_pkg::t_meta  i_meta,
    output logic            o_valid,
    input  logic            i_ready,
    output bfs_pkg::t_pix   o_smoothed,
    output bfs_pkg::t_meta  o_meta
);

    logic           r_va;
    logic           r_vb;
    logic           r_vc;
    bfs_pkg::t_x    r_x;
    bfs_pkg::t_prod r_prod;
    bfs_pkg::t_pix  r_smoothed;
    bfs_pkg::t_meta r_meta_a;
    bfs_pkg::t_meta r_meta_b;
    bfs_pkg::t_meta r_meta_c;

    logic           ready_a;
    logic           ready_b;
    logic           ready_c;
    bfs_pkg::t_quo  quo;
    bfs_pkg::t_pix  n_smoothed;

    assign ready_c = !r_vc || i_ready;
    assign ready_b = !r_vb || ready_c;
    assign ready_a = !r_va || ready_b;

    assign quo        = r_prod[bfs_pkg::PROD_W-1:bfs_pkg::RECIP_SHIFT];
    assign n_smoothed = (quo > bfs_pkg::t_quo'(bfs_pkg::PIX_MAX)) ?
                        bfs_pkg::PIX_MAX : quo[bfs_pkg::PIX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (ready_a) begin
                r_va <= i_valid;
            end
            if (ready_b) begin
                r_vb <= r_va;
            end
            if (ready_c) begin
                r_vc <= r_vb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a && i_valid) begin
            r_x      <= i_x;
            r_meta_a <= i_meta;
        end
        if (ready_b && r_va) begin
            r_prod   <= bfs_pkg::t_prod'(r_x) * bfs_pkg::t_prod'(bfs_pkg::RECIP_MUL);
            r_meta_b <= r_meta_a;
        end
        if (ready_c && r_vb) begin
            r_smoothed <= n_smoothed;
            r_meta_c   <= r_meta_b;
        end
    end

    assign o_ready    = ready_a;
    assign o_valid    = r_vc;
    assign o_smoothed = r_smoothed;
    assign o_meta     = r_meta_c;

endmodule

/* sv/box_filter_7x7_separable.sv */
// Separable 7x7 box filter: 8-bit raster pixels in, rounded 7x7 means out.
// Items pass the stage-1 register and the divider's input, product and output registers.
// Throughput: one item per clock unless output stalls; items from column 6 on do one read
// and one write on the line-buffer and column-sum memories. Input ready drops only when
// every stage is full. Reset (synchronous, active low) clears position counters, the pixel
// window, the column-sum fill mark and all stage valids; memories keep their contents.
module box_filter_7x7_separable #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
    input  logic        s_axis_tuser,   // [0] frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] smoothed, [17:8] centre_row,
                                        // [27:18] centre_col, [31:28] zero
    output logic        m_axis_tlast,   // frame_done
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(MAX_COLS);

    typedef logic [CW-1:0] t_col;

    bfs_pkg::t_cfg   r_width_cfg;
    bfs_pkg::t_cfg   r_height_cfg;

    logic            r_v1;
    bfs_pkg::t_hsum  r_hs1;
    t_col            r_cc1;
    bfs_pkg::t_line  r_line1;
    bfs_pkg::t_flags r_flags1;
    bfs_pkg::t_coord r_crow1;

    logic            s_accept;
    logic            ready1;
    logic            ready2;
    logic            emit_w;
    bfs_pkg::t_hsum  hs;
    t_col            cc;
    bfs_pkg::t_line  line;
    bfs_pkg::t_flags flags;
    bfs_pkg::t_coord crow;
    bfs_pkg::t_hsum  old_hs;
    bfs_pkg::t_csum  col_sum;
    bfs_pkg::t_csum  cs;
    bfs_pkg::t_x     x;
    bfs_pkg::t_meta  meta1;
    bfs_pkg::t_meta  out_meta;
    bfs_pkg::t_pix   smoothed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_cfg  <= bfs_pkg::WIDTH_RESET;
            r_height_cfg <= bfs_pkg::HEIGHT_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                bfs_pkg::REG_WIDTH:  r_width_cfg  <= pwdata[bfs_pkg::CFG_W-1:0];
                bfs_pkg::REG_HEIGHT: r_height_cfg <= pwdata[bfs_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            bfs_pkg::REG_WIDTH:  prdata = 32'(r_width_cfg);
            bfs_pkg::REG_HEIGHT: prdata = 32'(r_height_cfg);
            default:             prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    assign ready1        = !r_v1 || !r_flags1.emit || ready2;
    assign s_axis_tready = ready1;
    assign s_accept      = s_axis_tvalid && ready1;

    bfs_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (s_accept),
        .i_pixel       (s_axis_tdata),
        .i_frame_start (s_axis_tuser),
        .i_width_cfg   (r_width_cfg),
        .i_height_cfg  (r_height_cfg),
        .o_emit_w      (emit_w),
        .o_hs          (hs),
        .o_cc          (cc),
        .o_line        (line),
        .o_flags       (flags),
        .o_centre_row  (crow)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (ready1) begin
            r_v1 <= s_accept && emit_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept && emit_w) begin
            r_hs1    <= hs;
            r_cc1    <= cc;
            r_line1  <= line;
            r_flags1 <= flags;
            r_crow1  <= crow;
        end
    end

    bfs_sum_mem #(
        .COLS_W (CW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (s_accept && emit_w),
        .i_rd_line (line),
        .i_rd_col  (cc),
        .i_wr_en   (r_v1 && ready1),
        .i_wr_line (r_line1),
        .i_wr_col  (r_cc1),
        .i_wr_hs   (r_hs1),
        .i_wr_cs   (cs),
        .o_old_hs  (old_hs),
        .o_col_sum (col_sum)
    );

    // add the new row sum, from row 7 on drop the one from seven rows back; row 0 restarts
    always_comb begin
        if (r_flags1.row_zero) begin
            cs = bfs_pkg::t_csum'(r_hs1);
        end else if (r_flags1.row_ge7) begin
            cs = col_sum + bfs_pkg::t_csum'(r_hs1) - bfs_pkg::t_csum'(old_hs);
        end else begin
            cs = col_sum + bfs_pkg::t_csum'(r_hs1);
        end
    end

    assign x                = bfs_pkg::t_x'(cs) + bfs_pkg::ROUND_BIAS;
    assign meta1.centre_row = r_crow1;
    assign meta1.centre_col = bfs_pkg::t_coord'(r_cc1);
    assign meta1.done       = r_flags1.done;

    bfs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_v1 && r_flags1.emit),
        .o_ready    (ready2),
        .i_x        (x),
        .i_meta     (meta1),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_smoothed (smoothed),
        .o_meta     (out_meta)
    );

    assign m_axis_tdata = {{bfs_pkg::OUT_PAD_W{1'b0}}, out_meta.centre_col,
                           out_meta.centre_row, smoothed};
    assign m_axis_tlast = out_meta.done;

endmodule

/* sv/bfs_chk.sv */
// Port-level checker of the box filter and its bind to the top level.
`include "assert_macros.svh"

module bfs_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tready,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] i_m_tdata,
    input logic        i_m_tlast,
    input logic        i_pready
);

    `BFS_ASSERT_ALWAYS(a_pready_high, i_clk, i_pready, "pready dropped")
    `BFS_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !i_m_tvalid, "result after reset")
    `BFS_ASSERT(a_empty_out_takes_in, i_clk, i_rst_n, !i_m_tvalid |-> i_s_tready, "input blocked with output empty")
    `BFS_ASSERT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tlast), "stalled result changed")

endmodule

bind box_filter_7x7_separable bfs_chk u_bfs_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tlast  (m_axis_tlast),
    .i_pready   (pready)
);

/* sim/tb_top.sv */
// Self-checking testbench for the separable 7x7 box filter: directed and random pixel streams.
module tb_top;
    import bfs_pkg::*;

    localparam int MAX_COLS     = 1024;
    localparam int MAX_ROWS     = 1024;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_ITEMS = 1650;
    localparam int LONG_HOLD    = 400;

    localparam logic [2:0] WIDTH_ADDR  = {REG_WIDTH, 2'b00};
    localparam logic [2:0] HEIGHT_ADDR = {REG_HEIGHT, 2'b00};

    typedef struct packed {
        t_pix   smoothed;
        t_coord centre_row;
        t_coord centre_col;
        logic   frame_done;
    } mean_t;

    typedef enum {PAT_RANDOM, PAT_BANDS, PAT_WHITE, PAT_BLACK} pattern_e;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // [7:0] pixel
    logic        s_axis_tuser = 1'b0;   // [0] frame_start
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [7:0] smoothed, [17:8] centre_row,
                                        // [27:18] centre_col, [31:28] zero
    logic        m_axis_tlast;          // [0] frame_done
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    box_filter_7x7_separable #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // Filter state mirrored for prediction
    t_cfg  width_reg = WIDTH_RESET;
    t_cfg  height_reg = HEIGHT_RESET;
    int    cur_col = 0;
    int    cur_row = 0;
    t_pix  pix_window [WIN] = '{default: '0};
    t_hsum line_sums [WIN][MAX_COLS] = '{default: '{default: '0}};
    t_csum col_sums [MAX_COLS] = '{default: '0};

    mean_t expected_means [$];
    int    errors = 0;
    int    cycles = 0;
    int    burst_left = 0;
    bit    steady_sender = 1'b0;
    bit    hold_req = 1'b0;
    int    hold_left = 0;
    int    stall_left = 0;
    int    run_left = 0;

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int clamp_size(input t_cfg value, input int hi);
        if (value < WIN) return WIN;
        if (value > hi) return hi;
        return value;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    task automatic predict_mean(input t_pix pix, input logic fs);
        int    w, h, col, row, cc, line, hs, cs, mean, i;
        t_hsum old;
        mean_t r;
        w = clamp_size(width_reg, MAX_COLS);
        h = clamp_size(height_reg, MAX_ROWS);
        if (fs) begin
            cur_col = 0;
            cur_row = 0;
        end
        if (cur_col >= w) begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row >= h) cur_row = 0;
        col = cur_col;
        row = cur_row;
        for (i = 0; i < WIN - 1; i++) pix_window[i] = pix_window[i+1];
        pix_window[WIN-1] = pix;
        if (col >= WIN - 1) begin
            hs = 0;
            for (i = 0; i < WIN; i++) hs += pix_window[i];
            cc = col - HALF_WIN;
            line = row % WIN;
            old = line_sums[line][cc];
            line_sums[line][cc] = t_hsum'(hs);
            if (row == 0) cs = hs;
            else if (row < WIN) cs = col_sums[cc] + hs;
            else cs = col_sums[cc] + hs - old;
            cs = cs & 32'h3FFF;
            col_sums[cc] = t_csum'(cs);
            if (row >= WIN - 1) begin
                mean = (cs + 24) / 49;
                if (mean > 255) mean = 255;
                r.smoothed = t_pix'(mean);
                r.centre_row = t_coord'(row - HALF_WIN);
                r.centre_col = t_coord'(cc);
                r.frame_done = (row == h - 1) && (col == w - 1);
                expected_means.push_back(r);
            end
        end
        cur_col = col + 1;
        if (cur_col >= w) begin
            cur_col = 0;
            cur_row = row + 1;
            if (cur_row >= h) cur_row = 0;
        end
    endtask

    task automatic check_mean();
        mean_t want;
        if (expected_means.size() == 0) begin
            $error("unexpected result: tdata %h, tlast %b", m_axis_tdata, m_axis_tlast);
            errors++;
        end else begin
            want = expected_means.pop_front();
            check_field("smoothed", want.smoothed, m_axis_tdata[7:0]);
            check_field("centre_row", want.centre_row, m_axis_tdata[17:8]);
            check_field("centre_col", want.centre_col, m_axis_tdata[27:18]);
            check_field("frame_done", want.frame_done, m_axis_tlast);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) check_mean();
    end

    // Result side: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (run_left > 0) begin
                run_left--;
            end else begin
                run_left = $urandom_range(0, 40);
                stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
        end
    end

    task automatic apb_cycle(input logic wr, input logic [2:0] addr, input logic [31:0] word,
                             output logic [31:0] rdata);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= word;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_size_reg(input logic [2:0] addr, input t_cfg want);
        logic [31:0] rdata;
        apb_cycle(1'b0, addr, '0, rdata);
        check_field(addr == WIDTH_ADDR ? "image_width" : "image_height", want,
                    rdata[CFG_W-1:0]);
    endtask

    task automatic write_size(input logic [2:0] addr, input t_cfg value);
        logic [31:0] word, rdata;
        word = $urandom;
        word[CFG_W-1:0] = value;
        apb_cycle(1'b1, addr, word, rdata);
        if (addr == WIDTH_ADDR) width_reg = value;
        else height_reg = value;
        check_size_reg(addr, value);
    endtask

    task automatic send_pixel(input t_pix pix, input logic fs);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!steady_sender && $urandom_range(0, 2) != 0) gap = $urandom_range(1, 6);
        end
        burst_left--;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pix;
        s_axis_tuser <= fs;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_mean(pix, fs);
    endtask

    task automatic send_stream(input int n_items, input int cols, input pattern_e pat,
                               input bit with_start, input bit noisy);
        t_pix pix;
        logic fs;
        int   c;
        for (int k = 0; k < n_items; k++) begin
            c = k % cols;
            case (pat)
                PAT_WHITE: pix = PIX_MAX;
                PAT_BLACK: pix = '0;
                PAT_BANDS: pix = (c < 16) ? PIX_MAX : (c < 32) ? t_pix'(0) : t_pix'($urandom);
                default:   pix = t_pix'($urandom);
            endcase
            fs = (with_start && k == 0) || (noisy && $urandom_range(0, 99) == 0);
            send_pixel(pix, fs);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_means.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_reset_defaults();
        check_size_reg(WIDTH_ADDR, WIDTH_RESET);
        check_size_reg(HEIGHT_ADDR, HEIGHT_RESET);
        send_stream(20, clamp_size(width_reg, MAX_COLS), PAT_BANDS, 1'b1, 1'b0);
        wait_drained();
    endtask

    // Clamped to the widest, shortest frame; writes all seven lines of the line buffer
    task automatic test_size_clamps();
        write_size(WIDTH_ADDR, 11'd2047);
        write_size(HEIGHT_ADDR, 11'd0);
        send_stream(MAX_COLS * WIN, MAX_COLS, PAT_BANDS, 1'b1, 1'b0);
        wait_drained();
    endtask

    // Tallest frame, then run on past its end without a frame start
    task automatic test_tall_frame();
        write_size(WIDTH_ADDR, 11'd3);
        write_size(HEIGHT_ADDR, 11'd2047);
        send_stream(WIN * MAX_ROWS + WIN * 8, WIN, PAT_RANDOM, 1'b1, 1'b0);
        wait_drained();
    endtask

    task automatic test_small_frames();
        write_size(WIDTH_ADDR, 11'd7);
        write_size(HEIGHT_ADDR, 11'd7);
        send_stream(49, WIN, PAT_WHITE, 1'b1, 1'b0);
        send_stream(49, WIN, PAT_BLACK, 1'b0, 1'b0);
        send_stream(20, WIN, PAT_RANDOM, 1'b1, 1'b0);
        send_stream(49, WIN, PAT_RANDOM, 1'b1, 1'b0);
        wait_drained();
    endtask

    task automatic test_resize_mid_frame();
        write_size(WIDTH_ADDR, 11'd20);
        write_size(HEIGHT_ADDR, 11'd12);
        send_stream(150, 20, PAT_RANDOM, 1'b1, 1'b0);
        wait_drained();
        write_size(WIDTH_ADDR, 11'd9);
        send_stream(100, 9, PAT_WHITE, 1'b0, 1'b0);
        wait_drained();
        write_size(WIDTH_ADDR, 11'd30);
        write_size(HEIGHT_ADDR, 11'd8);
        send_stream(200, 30, PAT_WHITE, 1'b0, 1'b0);
        wait_drained();
        write_size(HEIGHT_ADDR, 11'd9);
        send_stream(300, 30, PAT_RANDOM, 1'b0, 1'b0);
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        write_size(WIDTH_ADDR, 11'd10);
        write_size(HEIGHT_ADDR, 11'd40);
        steady_sender = 1'b1;
        @(posedge i_clk);
        hold_req = 1'b1;
        send_stream(400, 10, PAT_RANDOM, 1'b1, 1'b0);
        steady_sender = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_frames();
        int   sent, n_frames, kind, w, h, n;
        t_cfg w_val, h_val;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       w_val = t_cfg'($urandom_range(0, 6));
                1:       w_val = t_cfg'($urandom_range(25, 64));
                default: w_val = t_cfg'($urandom_range(7, 24));
            endcase
            h_val = ($urandom_range(0, 7) == 0) ? t_cfg'($urandom_range(0, 6))
                                                : t_cfg'($urandom_range(7, 16));
            if (sent == 0 || $urandom_range(0, 3) != 0) write_size(WIDTH_ADDR, w_val);
            if (sent == 0 || $urandom_range(0, 3) != 0) write_size(HEIGHT_ADDR, h_val);
            w = clamp_size(width_reg, MAX_COLS);
            h = clamp_size(height_reg, MAX_ROWS);
            steady_sender = ($urandom_range(0, 3) == 0);
            n_frames = $urandom_range(1, 3);
            for (int f = 0; f < n_frames; f++) begin
                kind = $urandom_range(0, 9);
                n = (kind == 8) ? $urandom_range(1, w * h - 1) : w * h;
                send_stream(n, w, PAT_RANDOM, kind != 7, kind == 9);
                sent += n;
            end
            steady_sender = 1'b0;
            wait_drained();
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_size_clamps();
        test_tall_frame();
        test_small_frames();
        test_resize_mid_frame();
        test_output_backpressure();
        test_random_frames();
        wait_drained();
        if (errors == 0 && expected_means.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/bfs_pkg.sv
sv/bfs_front.sv
sv/bfs_sum_mem.sv
sv/bfs_div.sv
sv/box_filter_7x7_separable.sv
sv/bfs_chk.sv
sim/tb_top.sv
